### design/nps_pkg.sv
`timescale 1ns / 1ps
package nps_pkg;

   localparam int MAX_DIM    = 4;
   localparam int MAX_POINTS = 65536;

   localparam int COORD_W = 24;
   localparam int MAG_W   = COORD_W + 1;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int DIST_W  = 52;
   localparam int IDX_W   = 16;
   localparam int CNT_W   = 17;
   localparam int DIM_W   = 3;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   localparam logic [DIM_W-1:0] DIM_RESET = 3'd2;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_CAND  = 1'b1;

   // One classified item on its way from the front to the back
   typedef struct packed {
      logic              is_start;
      logic              compare;
      logic              last;
      logic [IDX_W-1:0]  index;
      logic [DIST_W-1:0] distance;
   } nps_item_type;

   typedef struct packed {
      logic is_start;
      logic compare;
      logic last;
      logic [IDX_W-1:0] index;
   } nps_meta_type;

   typedef struct packed {
      logic full;
      logic empty;
   } nps_fifo_status_type;

endpackage

### design/nps_front.sv
`timescale 1ns / 1ps
module nps_front
   import nps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_cmd,
   input  logic signed [COORD_W-1:0]  req_coord_a,
   input  logic signed [COORD_W-1:0]  req_coord_b,
   input  logic signed [COORD_W-1:0]  req_coord_c,
   input  logic signed [COORD_W-1:0]  req_coord_d,
   input  logic                       req_is_query_itself,
   input  logic                       req_last,
   input  logic                       push,
   output logic                       full,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [DIM_W-1:0]           csr_wdata,
   input  logic                       fifo_pop,
   output logic                       item_valid,
   output nps_item_type               item
);

   logic [DIM_W-1:0]          dim_ff, dim_in, dim_eff;
   logic signed [COORD_W-1:0] query_ff [MAX_DIM];
   logic signed [COORD_W-1:0] coord [MAX_DIM];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [FIFO_CNT_W-1:0]     credit_ff, credit_in;
   logic                      accept;
   nps_meta_type              meta0;
   logic [MAG_W-1:0]          mag0 [MAX_DIM];
   logic signed [MAG_W-1:0]   diff0 [MAX_DIM];

   logic                      v1_ff, v2_ff, v3_ff;
   nps_meta_type              meta1_ff, meta2_ff;
   logic [MAG_W-1:0]          mag1_ff [MAX_DIM];
   logic [SQ_W-1:0]           sq2_ff [MAX_DIM];
   nps_item_type              item_ff, item_in;

   assign coord[0] = req_coord_a;
   assign coord[1] = req_coord_b;
   assign coord[2] = req_coord_c;
   assign coord[3] = req_coord_d;

   assign accept    = push && !full;
   assign full      = (credit_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign csr_ready = 1'b1;

   assign dim_in = (csr_valid && csr_ready) ? csr_wdata : dim_ff;

   always_comb begin
      if (dim_ff == '0) begin
         dim_eff = DIM_W'(1);
      end else if (dim_ff > DIM_W'(MAX_DIM)) begin
         dim_eff = DIM_W'(MAX_DIM);
      end else begin
         dim_eff = dim_ff;
      end
   end

   // classify and number the item
   always_comb begin
      meta0    = '0;
      count_in = count_ff;
      if (req_cmd == CMD_START) begin
         meta0.is_start = 1'b1;
         count_in       = '0;
      end else if (count_ff < CNT_W'(MAX_POINTS)) begin
         meta0.compare = !req_is_query_itself;
         meta0.index   = count_ff[IDX_W-1:0];
         count_in      = count_ff + CNT_W'(1);
      end
      meta0.last = req_last;
      if (req_last) begin
         count_in = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_DIM; i++) begin
         diff0[i] = {coord[i][COORD_W-1], coord[i]} - {query_ff[i][COORD_W-1], query_ff[i]};
         if (DIM_W'(i) >= dim_eff) begin
            mag0[i] = '0;
         end else if (diff0[i][MAG_W-1]) begin
            mag0[i] = MAG_W'(-diff0[i]);
         end else begin
            mag0[i] = MAG_W'(diff0[i]);
         end
      end
   end

   always_comb begin
      item_in.is_start = meta2_ff.is_start;
      item_in.compare  = meta2_ff.compare;
      item_in.last     = meta2_ff.last;
      item_in.index    = meta2_ff.index;
      item_in.distance = DIST_W'(sq2_ff[0]) + DIST_W'(sq2_ff[1])
                       + DIST_W'(sq2_ff[2]) + DIST_W'(sq2_ff[3]);
   end

   assign credit_in = credit_ff + FIFO_CNT_W'(accept) - FIFO_CNT_W'(fifo_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff    <= DIM_RESET;
         count_ff  <= '0;
         credit_ff <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         for (int i = 0; i < MAX_DIM; i++) begin
            query_ff[i] <= '0;
         end
      end else begin
         dim_ff    <= dim_in;
         credit_ff <= credit_in;
         v1_ff     <= accept;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         if (accept) begin
            count_ff <= count_in;
            if (req_cmd == CMD_START) begin
               for (int i = 0; i < MAX_DIM; i++) begin
                  query_ff[i] <= coord[i];
               end
            end
         end
      end
   end

   // payload stages: no reset
   always_ff @(posedge clock) begin
      meta1_ff <= meta0;
      meta2_ff <= meta1_ff;
      item_ff  <= item_in;
      for (int i = 0; i < MAX_DIM; i++) begin
         mag1_ff[i] <= mag0[i];
         sq2_ff[i]  <= mag1_ff[i] * mag1_ff[i];
      end
   end

   assign item_valid = v3_ff;
   assign item       = item_ff;

endmodule

### design/nps_fifo.sv
`timescale 1ns / 1ps
module nps_fifo
   import nps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  nps_item_type        push_data,
   input  logic                pop_en,
   output nps_item_type        pop_data,
   output nps_fifo_status_type status
);

   nps_item_type          slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] fill_ff;

   assign status.full  = (fill_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push_en) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop_en) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         fill_ff <= fill_ff + FIFO_CNT_W'(push_en) - FIFO_CNT_W'(pop_en);
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/nps_back.sv
`timescale 1ns / 1ps
module nps_back
   import nps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  nps_item_type       head,
   input  logic               head_empty,
   output logic               head_pop,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_found,
   output logic [IDX_W-1:0]   rsp_best_index,
   output logic [DIST_W-1:0]  rsp_best_distance_sq
);

   logic              have_ff, have_in, have_upd;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in, dist_upd;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in, idx_upd;
   logic              out_valid_ff, out_valid_in;
   logic              slot_free;
   logic              found_ff;
   logic [IDX_W-1:0]  index_ff;
   logic [DIST_W-1:0] dist_ff;

   assign slot_free = !out_valid_ff || pop;
   assign head_pop  = !head_empty && (!head.last || slot_free);

   // running minimum; ties keep the earlier index
   always_comb begin
      have_upd = have_ff;
      dist_upd = best_dist_ff;
      idx_upd  = best_idx_ff;
      if (head.is_start) begin
         have_upd = 1'b0;
         dist_upd = '0;
         idx_upd  = '0;
      end else if (head.compare && (!have_ff || head.distance < best_dist_ff)) begin
         have_upd = 1'b1;
         dist_upd = head.distance;
         idx_upd  = head.index;
      end
   end

   always_comb begin
      have_in      = have_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      out_valid_in = out_valid_ff && !pop;
      if (head_pop) begin
         if (head.last) begin
            have_in      = 1'b0;
            best_dist_in = '0;
            best_idx_in  = '0;
            out_valid_in = 1'b1;
         end else begin
            have_in      = have_upd;
            best_dist_in = dist_upd;
            best_idx_in  = idx_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         best_dist_ff <= '0;
         best_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         best_dist_ff <= best_dist_in;
         best_idx_ff  <= best_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop && head.last) begin
         found_ff <= have_upd;
         index_ff <= have_upd ? idx_upd : '0;
         dist_ff  <= have_upd ? dist_upd : '0;
      end
   end

   assign empty                = !out_valid_ff;
   assign rsp_found            = found_ff;
   assign rsp_best_index       = index_ff;
   assign rsp_best_distance_sq = dist_ff;

endmodule

### design/nearest_point_search.sv
`timescale 1ns / 1ps
// Results pass the front pipeline (difference, square, sum), the queue and an output register.
// Throughput: one item per cycle while full is low; the front pipeline never stalls,
// and an 8-beat credit queue to the running-minimum stage sets how much back-pressure it absorbs.
// Reset (synchronous, active high): query point zero, dimension 2, queues and run state empty.
module nearest_point_search
   import nps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_cmd,
   input  logic signed [COORD_W-1:0]  req_coord_a,
   input  logic signed [COORD_W-1:0]  req_coord_b,
   input  logic signed [COORD_W-1:0]  req_coord_c,
   input  logic signed [COORD_W-1:0]  req_coord_d,
   input  logic                       req_is_query_itself,
   input  logic                       req_last,
   input  logic                       push,
   output logic                       full,
   output logic                       rsp_found,
   output logic [IDX_W-1:0]           rsp_best_index,
   output logic [DIST_W-1:0]          rsp_best_distance_sq,
   output logic                       empty,
   input  logic                       pop,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [DIM_W-1:0]           csr_wdata
);

   // Front: hold the query, number candidates, square the per-axis differences.
   // Every beat it issues reserves a queue slot, so the pipeline itself never stalls.
   logic                item_valid;
   nps_item_type        item;
   nps_item_type        head;
   nps_fifo_status_type fifo_status;
   logic                head_pop;

   nps_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_cmd             (req_cmd),
      .req_coord_a         (req_coord_a),
      .req_coord_b         (req_coord_b),
      .req_coord_c         (req_coord_c),
      .req_coord_d         (req_coord_d),
      .req_is_query_itself (req_is_query_itself),
      .req_last            (req_last),
      .push                (push),
      .full                (full),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_wdata           (csr_wdata),
      .fifo_pop            (head_pop),
      .item_valid          (item_valid),
      .item                (item)
   );

   // Decoupling queue between the arithmetic and the running minimum
   nps_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (item_valid),
      .push_data (item),
      .pop_en    (head_pop),
      .pop_data  (head),
      .status    (fifo_status)
   );

   // Back: keep the best distance and index, drop the run state after each result,
   // and hold the result in an output register until it is popped.
   nps_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .head_empty           (fifo_status.empty),
      .head_pop             (head_pop),
      .empty                (empty),
      .pop                  (pop),
      .rsp_found            (rsp_found),
      .rsp_best_index       (rsp_best_index),
      .rsp_best_distance_sq (rsp_best_distance_sq)
   );

`ifndef SYNTHESIS
   // the credit scheme must never let the queue overflow
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      item_valid |-> !fifo_status.full || head_pop)
      else $error("decoupling queue overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> !fifo_status.empty)
      else $error("back stage popped an empty queue");

   // a not-found result carries zero index and distance
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_found) |-> (rsp_best_index == '0 && rsp_best_distance_sq == '0))
      else $error("not-found result with non-zero payload");
`endif

endmodule

### verif/tb_nearest_point_search.sv
`timescale 1ns / 1ps
module tb_nearest_point_search;
   import nps_pkg::*;

   typedef logic signed [COORD_W-1:0] coord_type;

   // One request beat as it goes onto the req_ ports
   typedef struct {
      logic      cmd;
      coord_type coord [4];
      logic      skip;
      logic      last;
   } point_beat_type;

   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  index;
      logic [DIST_W-1:0] distance;
   } search_result_type;

   localparam int HOLD_OFF_CYCLES = 10;   // margin for the block's pipeline and queue to empty
   localparam int STALL_LIMIT     = 3000;
   localparam int RUNS_QUOTA      = 60;   // beats per random sub-phase, eight sub-phases

   localparam coord_type COORD_MIN = 24'sh800000;
   localparam coord_type COORD_MAX = 24'sh7FFFFF;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_cmd = CMD_START;
   coord_type                 req_coord_a = '0;
   coord_type                 req_coord_b = '0;
   coord_type                 req_coord_c = '0;
   coord_type                 req_coord_d = '0;
   logic                      req_is_query_itself = 1'b0;
   logic                      req_last = 1'b0;
   logic                      push = 1'b0;
   logic                      full;
   logic                      rsp_found;
   logic [IDX_W-1:0]          rsp_best_index;
   logic [DIST_W-1:0]         rsp_best_distance_sq;
   logic                      empty;
   logic                      pop = 1'b0;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [DIM_W-1:0]          csr_wdata = DIM_RESET;

   nearest_point_search dut (
      .clock                (clock),
      .reset                (reset),
      .req_cmd              (req_cmd),
      .req_coord_a          (req_coord_a),
      .req_coord_b          (req_coord_b),
      .req_coord_c          (req_coord_c),
      .req_coord_d          (req_coord_d),
      .req_is_query_itself  (req_is_query_itself),
      .req_last             (req_last),
      .push                 (push),
      .full                 (full),
      .rsp_found            (rsp_found),
      .rsp_best_index       (rsp_best_index),
      .rsp_best_distance_sq (rsp_best_distance_sq),
      .empty                (empty),
      .pop                  (pop),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shared bookkeeping
   // ------------------------------------------------------------------
   point_beat_type    pending_beats [$];
   search_result_type expected_results [$];
   point_beat_type    beat_on_bus;
   longint unsigned beats_queued = 0;
   longint unsigned beats_accepted = 0;
   int unsigned    mismatches = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    take_stall_pct = 0;

   // Own copy of the search state; dimension tracks what was last written
   coord_type         query_pt [4] = '{default: '0};
   logic [DIST_W-1:0] best_dist = '0;
   logic [IDX_W-1:0]  best_idx = '0;
   logic              have_best = 1'b0;
   logic [CNT_W-1:0]  run_count = '0;
   logic [DIM_W-1:0]  dimension = DIM_RESET;

   // Generator's idea of the current query, so candidates land near it
   coord_type         gen_query [4] = '{default: '0};

   // ------------------------------------------------------------------
   // Nearest point predictor: advance the search by one accepted beat
   // ------------------------------------------------------------------
   task automatic search_step(input point_beat_type b);
      int unsigned       dims;
      longint            diff;
      logic [DIST_W-1:0] dist_sq;
      search_result_type res;
      if (b.cmd == CMD_START) begin
         // a start loads the query and throws away any run in progress
         for (int i = 0; i < 4; i++) query_pt[i] = b.coord[i];
         have_best = 1'b0;
         best_dist = '0;
         best_idx  = '0;
         run_count = '0;
      end else if (run_count < MAX_POINTS) begin
         if (!b.skip) begin
            // clamp the dimension into 1..MAX_DIM on every candidate
            dims = (dimension == 0) ? 1 : ((dimension > MAX_DIM) ? MAX_DIM : dimension);
            dist_sq = '0;
            for (int i = 0; i < dims; i++) begin
               diff    = longint'(b.coord[i]) - longint'(query_pt[i]);
               dist_sq = dist_sq + DIST_W'(diff * diff);
            end
            // strict compare: a tie keeps the earlier index
            if (!have_best || dist_sq < best_dist) begin
               best_dist = dist_sq;
               best_idx  = run_count[IDX_W-1:0];
               have_best = 1'b1;
            end
         end
         // a skipped candidate still takes an index
         run_count = run_count + 1'b1;
      end
      if (b.last) begin
         res.found    = have_best;
         res.index    = have_best ? best_idx : '0;
         res.distance = have_best ? best_dist : '0;
         expected_results.push_back(res);
         have_best = 1'b0;
         best_dist = '0;
         best_idx  = '0;
         run_count = '0;
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   task automatic check_search_result();
      search_result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result beat with nothing expected: found=%0d index=%0d dist=%0d",
                     $time, rsp_found, rsp_best_index, rsp_best_distance_sq);
      end else begin
         want = expected_results.pop_front();
         if (rsp_found !== want.found)
            flag_mismatch("found", want.found, rsp_found);
         if (rsp_best_index !== want.index)
            flag_mismatch("best_index", want.index, rsp_best_index);
         if (rsp_best_distance_sq !== want.distance)
            flag_mismatch("best_distance_sq", want.distance, rsp_best_distance_sq);
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: hold a beat until it is taken, then maybe idle
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            search_step(beat_on_bus);
            beats_accepted++;
         end
         // the bus is free when nothing is offered or the offer was just taken
         if (!push || !full) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat_on_bus = pending_beats.pop_front();
               req_cmd             <= beat_on_bus.cmd;
               req_coord_a         <= beat_on_bus.coord[0];
               req_coord_b         <= beat_on_bus.coord[1];
               req_coord_c         <= beat_on_bus.coord[2];
               req_coord_d         <= beat_on_bus.coord[3];
               req_is_query_itself <= beat_on_bus.skip;
               req_last            <= beat_on_bus.last;
               push                <= 1'b1;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: take result beats with random back-pressure
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_search_result();
         pop <= ($urandom_range(99) >= take_stall_pct);
      end
   end

   // Watchdog: count cycles in which no beat moves on any channel
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic add_beat(input logic cmd, input coord_type a, input coord_type b,
                           input coord_type c, input coord_type d, input logic skip,
                           input logic last);
      point_beat_type beat;
      beat.cmd      = cmd;
      beat.coord[0] = a;
      beat.coord[1] = b;
      beat.coord[2] = c;
      beat.coord[3] = d;
      beat.skip     = skip;
      beat.last     = last;
      pending_beats.push_back(beat);
      beats_queued++;
   endtask

   // Partly near the centre so ties and close calls turn up, with extremes and noise
   function automatic coord_type pick_coord(input coord_type centre);
      case ($urandom_range(9))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2, 3:    return coord_type'(int'(centre) + int'($urandom_range(8)) - 4);
         4:       return centre;
         5:       return coord_type'(int'($urandom_range(64)) - 32);
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic add_candidate(input logic last);
      add_beat(CMD_CAND, pick_coord(gen_query[0]), pick_coord(gen_query[1]),
               pick_coord(gen_query[2]), pick_coord(gen_query[3]),
               ($urandom_range(99) < 15), last);
   endtask

   task automatic queue_directed();
      // candidate before any start: compared with the all-zero query
      add_beat(CMD_CAND, COORD_MIN, COORD_MAX, 24'sd5, -24'sd5, 1'b0, 1'b1);
      // empty run: a start that is also last
      add_beat(CMD_START, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b0, 1'b1);
      // fresh run on the kept query where every candidate is the query itself
      add_beat(CMD_CAND, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1, 1'b0);
      add_beat(CMD_CAND, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
      // ties keep the earlier index; a skipped exact match must not win
      add_beat(CMD_START, 24'sh000100, -24'sh000200, 24'sd0, 24'sd0, 1'b0, 1'b0);
      add_beat(CMD_CAND, 24'sh000103, -24'sh000200, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
      add_beat(CMD_CAND, 24'sh0000FD, -24'sh000200, 24'sd0, 24'sd0, 1'b0, 1'b0);
      add_beat(CMD_CAND, 24'sh000100, -24'sh000200, 24'sd0, 24'sd0, 1'b1, 1'b0);
      add_beat(CMD_CAND, 24'sh000100, -24'sh0001FE, 24'sd9, 24'sd9, 1'b0, 1'b0);
      add_beat(CMD_CAND, COORD_MIN, COORD_MAX, 24'sd0, 24'sd0, 1'b0, 1'b0);
      // restart in the middle of a run drops what came before
      add_beat(CMD_START, 24'sd0, 24'sd0, COORD_MIN, COORD_MAX, 1'b0, 1'b0);
      add_beat(CMD_CAND, 24'sd1, 24'sd1, 24'sd0, 24'sd0, 1'b0, 1'b0);
      add_beat(CMD_CAND, -24'sd1, -24'sd1, 24'sd0, 24'sd0, 1'b0, 1'b0);
      add_beat(CMD_CAND, 24'sd3, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b1);
      // candidates with no new start run against the kept query
      add_beat(CMD_CAND, 24'sd0, 24'sd0, COORD_MAX, COORD_MAX, 1'b0, 1'b1);
      add_beat(CMD_CAND, COORD_MAX, COORD_MIN, 24'sd0, 24'sd0, 1'b0, 1'b0);
      add_beat(CMD_CAND, COORD_MIN, COORD_MAX, 24'sd0, 24'sd0, 1'b0, 1'b1);
      gen_query = '{default: '0};
   endtask

   task automatic queue_random_runs(input int unsigned quota);
      int unsigned made;
      int unsigned kind;
      int unsigned n_cand;
      made = 0;
      while (made < quota) begin
         kind = $urandom_range(99);
         if (kind < 85) begin
            // well-formed run: start, some candidates, last on the final beat
            n_cand = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(6);
            for (int i = 0; i < 4; i++)
               gen_query[i] = ($urandom_range(3) == 0) ? pick_coord('0)
                                                        : coord_type'($urandom);
            add_beat(CMD_START, gen_query[0], gen_query[1], gen_query[2], gen_query[3],
                     1'($urandom_range(1)), (n_cand == 0));
            for (int i = 0; i < n_cand; i++) add_candidate(i == n_cand - 1);
            made += n_cand + 1;
         end else if (kind < 90) begin
            // candidates against the query left over from the last run
            n_cand = $urandom_range(1, 4);
            for (int i = 0; i < n_cand; i++) add_candidate(i == n_cand - 1);
            made += n_cand;
         end else if (kind < 95) begin
            // open a run and abandon it; the next start restarts
            add_beat(CMD_START, coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), coord_type'($urandom), 1'b0, 1'b0);
            add_candidate(1'b0);
            made += 2;
         end else begin
            // broken stream: every field at random
            add_beat(1'($urandom_range(1)), coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), coord_type'($urandom), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
            made += 1;
         end
      end
   endtask

   // Hold until every beat is taken and every result has come back, then
   // let the pipeline empty of beats that produce no result
   task automatic drain();
      while (beats_accepted != beats_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
   endtask

   task automatic write_dimension(input logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      dimension = value;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      logic [DIM_W-1:0] dim_plan [8];
      int unsigned      idle_plan [4];
      int unsigned      stall_plan [4];
      dim_plan   = '{3'd1, 3'd3, 3'd0, 3'd7, 3'd4, 3'd2, 3'd5, 3'd6};
      idle_plan  = '{0, 71, 0, 30};
      stall_plan = '{0, 0, 71, 30};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cases at the reset dimension, no idling
      queue_directed();
      drain();

      // random runs: two dimensions per idling phase, all eight codes in all
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_plan[p];
         take_stall_pct = stall_plan[p];
         for (int k = 0; k < 2; k++) begin
            write_dimension(dim_plan[2 * p + k]);
            queue_random_runs(RUNS_QUOTA);
            drain();
         end
      end

      send_idle_pct  = 0;
      take_stall_pct = 0;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
